// File: rtl/core/aese_pkg.sv
`default_nettype none

package aese_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ARG_W  = 16;
    localparam int unsigned BYTE_W = 8;
    // Five decimal digits cover any 16-bit value.
    localparam int unsigned DIGITS = 5;
    localparam int unsigned BCD_W  = 4 * DIGITS;

    localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ROW    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STYLE_RESET  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCROLL_RESET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE         = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIMIT_SCROLL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SCROLL_UP    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN  = 3'd7;

    localparam logic [BYTE_W-1:0] CHR_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] CHR_BRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CHR_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_TWO     = 8'h32;
    localparam logic [BYTE_W-1:0] CHR_UP_J    = 8'h4A;
    localparam logic [BYTE_W-1:0] CHR_UP_K    = 8'h4B;
    localparam logic [BYTE_W-1:0] CHR_LO_M    = 8'h6D;
    localparam logic [BYTE_W-1:0] CHR_UP_H    = 8'h48;
    localparam logic [BYTE_W-1:0] CHR_LO_R    = 8'h72;
    localparam logic [BYTE_W-1:0] CHR_UP_S    = 8'h53;
    localparam logic [BYTE_W-1:0] CHR_UP_T    = 8'h54;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ARG_W-1:0] first_arg;
        logic [ARG_W-1:0] second_arg;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_ESC,
        ST_CSI,
        ST_FIX,
        ST_NUM1,
        ST_SEP,
        ST_NUM2,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/ansi_escape_sequence_encoder.sv
`default_nettype none

// Channel   Ports                          Direction  Word
// input     s_valid, s_ready, s_data       in         command, first_arg, second_arg
// result    m_valid, m_ready, m_data       out        out_byte, last (one byte per word)
//
// A fixed sequence starts in the cycle after its command is taken and sends one byte per cycle.
// Numeric commands first pass both arguments through two bit-serial binary to BCD
// converters, then send one byte per cycle: up to 14 bytes.
// A new command is taken only once the final byte of the previous one sits in the output
// register. Reset is synchronous and clears the sequencer and the output valid.
// A stall on the result channel holds the sequencer; conversion runs regardless.
module ansi_escape_sequence_encoder (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire aese_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output aese_pkg::out_word_t      m_data
);
    import aese_pkg::*;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [ARG_W-1:0] bin1_reg, bin2_reg;
    logic [BCD_W-1:0] bcd1_reg, bcd2_reg;
    logic [3:0]       bit_cnt_reg;
    logic [2:0]       dig_cnt_reg, dig_cnt_next;
    logic             tail_idx_reg, tail_idx_next;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic             accept;
    logic             adv;
    logic             emit;
    out_word_t        emit_word;
    logic             numeric;

    // One double-dabble step: correct every digit, then shift the next bit in.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Number of significant digits, at least one so that zero prints as "0".
    function automatic logic [2:0] num_digits(input logic [BCD_W-1:0] bcd);
        logic [2:0] n;
        n = 3'd1;
        for (int d = 1; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] != 4'd0) begin
                n = 3'(d + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] digit_chr(input logic [BCD_W-1:0] bcd,
                                                    input logic [2:0] cnt);
        logic [3:0] nib;
        unique case (cnt)
            3'd5:    nib = bcd[19:16];
            3'd4:    nib = bcd[15:12];
            3'd3:    nib = bcd[11:8];
            3'd2:    nib = bcd[7:4];
            default: nib = bcd[3:0];
        endcase
        return CHR_ZERO | {4'd0, nib};
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign adv     = !out_valid_reg || m_ready;
    assign numeric = cmd_reg[2];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_data.command[2] ? ST_CONV : ST_ESC;
                end
            end
            ST_CONV: begin
                if (bit_cnt_reg == 4'd15) begin
                    state_next = ST_ESC;
                end
            end
            ST_ESC: begin
                if (adv) begin
                    state_next = ST_CSI;
                end
            end
            ST_CSI: begin
                if (adv) begin
                    state_next = numeric ? ST_NUM1 : ST_FIX;
                end
            end
            ST_FIX: begin
                if (adv && (tail_idx_reg || cmd_reg == CMD_SCROLL_RESET)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_NUM1: begin
                if (adv && dig_cnt_reg == 3'd1) begin
                    state_next = (cmd_reg == CMD_MOVE || cmd_reg == CMD_LIMIT_SCROLL)
                                 ? ST_SEP : ST_FINAL;
                end
            end
            ST_SEP: begin
                if (adv) begin
                    state_next = ST_NUM2;
                end
            end
            ST_NUM2: begin
                if (adv && dig_cnt_reg == 3'd1) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (adv) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        emit           = 1'b0;
        emit_word      = '{out_byte: CHR_ESC, last: 1'b0};
        dig_cnt_next   = dig_cnt_reg;
        tail_idx_next  = tail_idx_reg;
        unique case (state_reg)
            ST_ESC: begin
                emit = 1'b1;
            end
            ST_CSI: begin
                emit               = 1'b1;
                emit_word.out_byte = CHR_BRACKET;
                if (adv) begin
                    dig_cnt_next  = num_digits(bcd1_reg);
                    tail_idx_next = 1'b0;
                end
            end
            ST_FIX: begin
                emit = 1'b1;
                unique case (cmd_reg)
                    CMD_CLEAR:       emit_word.out_byte = tail_idx_reg ? CHR_UP_J : CHR_TWO;
                    CMD_CLEAR_ROW:   emit_word.out_byte = tail_idx_reg ? CHR_UP_K : CHR_TWO;
                    CMD_STYLE_RESET: emit_word.out_byte = tail_idx_reg ? CHR_LO_M : CHR_ZERO;
                    default:         emit_word.out_byte = CHR_LO_R;
                endcase
                emit_word.last = tail_idx_reg || (cmd_reg == CMD_SCROLL_RESET);
                if (adv) begin
                    tail_idx_next = 1'b1;
                end
            end
            ST_NUM1: begin
                emit               = 1'b1;
                emit_word.out_byte = digit_chr(bcd1_reg, dig_cnt_reg);
                if (adv) begin
                    dig_cnt_next = dig_cnt_reg - 3'd1;
                end
            end
            ST_SEP: begin
                emit               = 1'b1;
                emit_word.out_byte = CHR_SEMI;
                if (adv) begin
                    dig_cnt_next = num_digits(bcd2_reg);
                end
            end
            ST_NUM2: begin
                emit               = 1'b1;
                emit_word.out_byte = digit_chr(bcd2_reg, dig_cnt_reg);
                if (adv) begin
                    dig_cnt_next = dig_cnt_reg - 3'd1;
                end
            end
            ST_FINAL: begin
                emit = 1'b1;
                emit_word.last = 1'b1;
                unique case (cmd_reg)
                    CMD_MOVE:      emit_word.out_byte = CHR_UP_H;
                    CMD_SCROLL_UP: emit_word.out_byte = CHR_UP_S;
                    CMD_SCROLL_DOWN: emit_word.out_byte = CHR_UP_T;
                    default:       emit_word.out_byte = CHR_LO_R;
                endcase
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (adv) begin
                out_valid_reg <= emit;
            end
            if (accept) begin
                bit_cnt_reg <= '0;
            end else if (state_reg == ST_CONV) begin
                bit_cnt_reg <= bit_cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dig_cnt_reg  <= dig_cnt_next;
        tail_idx_reg <= tail_idx_next;
        if (adv && emit) begin
            out_word_reg <= emit_word;
        end
        if (accept) begin
            cmd_reg  <= s_data.command;
            bcd1_reg <= '0;
            bcd2_reg <= '0;
            // Cursor move sends the row first; scroll up and down use only the low byte of the first argument.
            unique case (s_data.command)
                CMD_MOVE: begin
                    bin1_reg <= s_data.second_arg + ARG_W'(1);
                    bin2_reg <= s_data.first_arg + ARG_W'(1);
                end
                CMD_LIMIT_SCROLL: begin
                    bin1_reg <= s_data.first_arg + ARG_W'(1);
                    bin2_reg <= s_data.second_arg + ARG_W'(1);
                end
                default: begin
                    bin1_reg <= {8'd0, s_data.first_arg[7:0]};
                    bin2_reg <= '0;
                end
            endcase
        end else if (state_reg == ST_CONV) begin
            bcd1_reg <= dd_step(bcd1_reg, bin1_reg[ARG_W-1]);
            bcd2_reg <= dd_step(bcd2_reg, bin2_reg[ARG_W-1]);
            bin1_reg <= {bin1_reg[ARG_W-2:0], 1'b0};
            bin2_reg <= {bin2_reg[ARG_W-2:0], 1'b0};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

`default_nettype wire
